// ===== hdl/dcdc_pkg.sv =====
// Shared types, constants and tables of the day count to calendar converter.
`default_nettype none

package dcdc_pkg;

    // Pipeline depth from input register to output register.
    localparam int LATENCY = 10;
    // Stages that the time-of-day path waits to line up with the date path.
    localparam int TOD_PAD = 7;

    localparam int DAYS_400Y    = 146097;
    localparam int DAYS_100Y    = 36524;
    localparam int DAYS_4Y      = 1461;
    localparam int DAYS_1Y      = 365;
    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_HR  = 3600;
    localparam int SECS_PER_MIN = 60;

    // Reciprocals floor(2^k / d), each with k at least the width of the dividend,
    // so that the quotient estimate is never more than one below the true value.
    localparam int REC_400Y = 114; // k = 24
    localparam int REC_100Y = 7;   // k = 18
    localparam int REC_4Y   = 44;  // k = 16
    localparam int REC_1Y   = 5;   // k = 11
    localparam int REC_HR   = 36;  // k = 17
    localparam int REC_MIN  = 68;  // k = 12

    // Leap rule indices: year in a 4-year cycle, 4-year cycle in a century, century in 400 years.
    localparam logic [1:0] LEAP_Q1   = 2'd3;
    localparam logic [4:0] CENT_Q4   = 5'd24;
    localparam logic [1:0] LEAP_Q100 = 2'd3;

    typedef struct packed {
        logic [23:0] time_seconds;
        logic [23:0] day_number;
    } t_in_item;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        valid_res;
    } t_out_item;

    // Day count split into its cycle quotients and the day within the year.
    typedef struct packed {
        logic [6:0] q400;
        logic [1:0] q100;
        logic [4:0] q4;
        logic [1:0] q1;
        logic [8:0] doy;
    } t_day_parts;

    typedef struct packed {
        logic       ok;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // First day of month idx (0 is January) counted from the start of the year.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && idx >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dcdc_day_split.sv =====
// Splits the day count into 400-, 100-, 4- and 1-year cycles over eight stages.
`default_nettype none

module dcdc_day_split (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [23:0]        i_day_number,
    output dcdc_pkg::t_day_parts    o_parts
);
    import dcdc_pkg::*;

    // Stage 1: 400-year quotient estimate.
    logic [23:0] r1_n;
    logic [6:0]  r1_qe;
    logic [30:0] prod1;
    // Stage 2: correction.
    logic [6:0]  r2_q400;
    logic [17:0] r2_n;
    logic [23:0] rem2;
    logic        ge2;
    logic [6:0]  n_q400;
    logic [17:0] n_n1;
    // Stage 3: 100-year estimate.
    logic [6:0]  r3_q400;
    logic [17:0] r3_n;
    logic [2:0]  r3_qe;
    logic [20:0] prod3;
    // Stage 4: correction with the clamp to three.
    logic [6:0]  r4_q400;
    logic [1:0]  r4_q100;
    logic [15:0] r4_n;
    logic [17:0] rem4;
    logic        ge4;
    logic [2:0]  n_q100;
    logic [17:0] n_n2;
    // Stage 5: 4-year estimate.
    logic [6:0]  r5_q400;
    logic [1:0]  r5_q100;
    logic [15:0] r5_n;
    logic [4:0]  r5_qe;
    logic [21:0] prod5;
    // Stage 6: correction.
    logic [6:0]  r6_q400;
    logic [1:0]  r6_q100;
    logic [4:0]  r6_q4;
    logic [10:0] r6_n;
    logic [15:0] rem6;
    logic        ge6;
    logic [4:0]  n_q4;
    logic [15:0] n_n3;
    // Stage 7: 1-year estimate.
    logic [6:0]  r7_q400;
    logic [1:0]  r7_q100;
    logic [4:0]  r7_q4;
    logic [10:0] r7_n;
    logic [2:0]  r7_qe;
    logic [13:0] prod7;
    // Stage 8: correction with the clamp to three.
    t_day_parts  r8_parts;
    logic [10:0] rem8;
    logic        ge8;
    logic [2:0]  n_q1;
    logic [10:0] n_doy;

    always_comb begin
        prod1  = 31'(i_day_number) * 31'(REC_400Y);

        rem2   = r1_n - 24'(r1_qe) * 24'(DAYS_400Y);
        ge2    = rem2 >= 24'(DAYS_400Y);
        n_q400 = r1_qe + 7'(ge2);
        n_n1   = ge2 ? 18'(rem2 - 24'(DAYS_400Y)) : rem2[17:0];

        prod3  = 21'(r2_n) * 21'(REC_100Y);

        // A quotient of four only occurs on the last day of a 400-year cycle
        // and is held at three, leaving that day in the final century.
        rem4   = r3_n - 18'(r3_qe) * 18'(DAYS_100Y);
        ge4    = (rem4 >= 18'(DAYS_100Y)) && (r3_qe < 3'd3);
        n_q100 = r3_qe + 3'(ge4);
        n_n2   = ge4 ? (rem4 - 18'(DAYS_100Y)) : rem4;

        prod5  = 22'(r4_n) * 22'(REC_4Y);

        rem6   = r5_n - 16'(r5_qe) * 16'(DAYS_4Y);
        ge6    = rem6 >= 16'(DAYS_4Y);
        n_q4   = r5_qe + 5'(ge6);
        n_n3   = ge6 ? (rem6 - 16'(DAYS_4Y)) : rem6;

        prod7  = 14'(r6_n) * 14'(REC_1Y);

        rem8   = r7_n - 11'(r7_qe) * 11'(DAYS_1Y);
        ge8    = (rem8 >= 11'(DAYS_1Y)) && (r7_qe < 3'd3);
        n_q1   = r7_qe + 3'(ge8);
        n_doy  = ge8 ? (rem8 - 11'(DAYS_1Y)) : rem8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_n           <= i_day_number;
            r1_qe          <= prod1[30:24];

            r2_q400        <= n_q400;
            r2_n           <= n_n1;

            r3_q400        <= r2_q400;
            r3_n           <= r2_n;
            r3_qe          <= prod3[20:18];

            r4_q400        <= r3_q400;
            r4_q100        <= n_q100[1:0];
            r4_n           <= n_n2[15:0];

            r5_q400        <= r4_q400;
            r5_q100        <= r4_q100;
            r5_n           <= r4_n;
            r5_qe          <= prod5[20:16];

            r6_q400        <= r5_q400;
            r6_q100        <= r5_q100;
            r6_q4          <= n_q4;
            r6_n           <= n_n3[10:0];

            r7_q400        <= r6_q400;
            r7_q100        <= r6_q100;
            r7_q4          <= r6_q4;
            r7_n           <= r6_n;
            r7_qe          <= prod7[13:11];

            r8_parts.q400  <= r7_q400;
            r8_parts.q100  <= r7_q100;
            r8_parts.q4    <= r7_q4;
            r8_parts.q1    <= n_q1[1:0];
            r8_parts.doy   <= n_doy[8:0];
        end
    end

    assign o_parts = r8_parts;

endmodule

`default_nettype wire

// ===== hdl/dcdc_tod_split.sv =====
// Splits seconds since midnight into hour, minute and second, aligned to the date path.
`default_nettype none

module dcdc_tod_split (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [23:0]   i_time_seconds,
    output dcdc_pkg::t_tod     o_tod
);
    import dcdc_pkg::*;

    logic        r1_ok;
    logic [16:0] r1_s;
    logic [5:0]  r1_he;
    logic [22:0] prod1;

    logic        r2_ok;
    logic [5:0]  r2_hour;
    logic [11:0] r2_r;
    logic [16:0] rem2;
    logic        ge2;
    logic [5:0]  n_hour;
    logic [16:0] n_r;

    logic        r3_ok;
    logic [5:0]  r3_hour;
    logic [11:0] r3_r;
    logic [6:0]  r3_me;
    logic [18:0] prod3;

    logic [11:0] rem4;
    logic        ge4;
    logic [6:0]  n_min;
    logic [11:0] n_sec;
    t_tod        n_tod;

    t_tod        r_pad [TOD_PAD];

    always_comb begin
        // Only values below one day are used, and those fit in 17 bits.
        prod1  = 23'(i_time_seconds[16:0]) * 23'(REC_HR);

        rem2   = r1_s - 17'(r1_he) * 17'(SECS_PER_HR);
        ge2    = rem2 >= 17'(SECS_PER_HR);
        n_hour = r1_he + 6'(ge2);
        n_r    = ge2 ? (rem2 - 17'(SECS_PER_HR)) : rem2;

        prod3  = 19'(r2_r) * 19'(REC_MIN);

        rem4   = r3_r - 12'(r3_me) * 12'(SECS_PER_MIN);
        ge4    = rem4 >= 12'(SECS_PER_MIN);
        n_min  = r3_me + 7'(ge4);
        n_sec  = ge4 ? (rem4 - 12'(SECS_PER_MIN)) : rem4;

        n_tod.ok     = r3_ok;
        n_tod.hour   = r3_hour[4:0];
        n_tod.minute = n_min[5:0];
        n_tod.second = n_sec[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok   <= i_time_seconds < 24'(SECS_PER_DAY);
            r1_s    <= i_time_seconds[16:0];
            r1_he   <= prod1[22:17];

            r2_ok   <= r1_ok;
            r2_hour <= n_hour;
            r2_r    <= n_r[11:0];

            r3_ok   <= r2_ok;
            r3_hour <= r2_hour;
            r3_r    <= r2_r;
            r3_me   <= prod3[18:12];

            r_pad[0] <= n_tod;
            for (int k = 1; k < TOD_PAD; k++) begin
                r_pad[k] <= r_pad[k-1];
            end
        end
    end

    assign o_tod = r_pad[TOD_PAD-1];

endmodule

`default_nettype wire

// ===== hdl/dcdc_month.sv =====
// Builds the year, finds the month and the day within it from the day of the year.
`default_nettype none

module dcdc_month (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire dcdc_pkg::t_day_parts   i_parts,
    output logic [15:0]                 o_year,
    output logic [3:0]                  o_month,
    output logic [4:0]                  o_day_of_month
);
    import dcdc_pkg::*;

    logic [15:0] r9_year;
    logic [3:0]  r9_month;
    logic [8:0]  r9_start;
    logic [8:0]  r9_doy;

    logic [15:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_dom;

    logic        leap;
    logic [8:0]  thr;
    logic [15:0] n_year;
    logic [3:0]  n_month;
    logic [8:0]  n_start;
    logic [8:0]  n_dom;

    always_comb begin
        n_year = 16'd1 + 16'(i_parts.q400) * 16'd400 + 16'(i_parts.q100) * 16'd100
               + 16'({i_parts.q4, 2'b00}) + 16'(i_parts.q1);
        // Leap when the year closes a 4-year cycle, unless it also closes a
        // century that does not close the 400-year cycle.
        leap   = (i_parts.q1 == LEAP_Q1)
              && ((i_parts.q4 != CENT_Q4) || (i_parts.q100 == LEAP_Q100));
        n_month = 4'd1;
        n_start = 9'd0;
        for (int k = 1; k < 12; k++) begin
            thr = month_start(4'(k), leap);
            if (i_parts.doy >= thr) begin
                n_month = 4'(k + 1);
                n_start = thr;
            end
        end
        n_dom = r9_doy - r9_start + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_year  <= n_year;
            r9_month <= n_month;
            r9_start <= n_start;
            r9_doy   <= i_parts.doy;

            r_year   <= r9_year;
            r_month  <= r9_month;
            r_dom    <= n_dom[4:0];
        end
    end

    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_dom;

endmodule

`default_nettype wire

// ===== hdl/day_count_datetime_to_calendar_top.sv =====
// Throughput: one item per cycle unless the output stalls; the date path takes four
// constant divisions, each an estimate stage by reciprocal multiply and a correction
// stage, then two month stages.
// A stalled output holds the whole pipeline; no item is dropped or repeated.
// Reset clears the stage valid bits only; payload registers are not reset.
`default_nettype none

module day_count_datetime_to_calendar_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire dcdc_pkg::t_in_item     i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output dcdc_pkg::t_out_item         o_out_data
);
    import dcdc_pkg::*;

    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;
    logic               en;

    t_day_parts  parts;
    t_tod        tod;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;

    // The pipeline moves as one whenever the last stage is empty or being taken.
    assign en         = !r_vld[LATENCY-1] || i_out_ready;
    assign o_in_ready = en;
    assign n_vld      = {r_vld[LATENCY-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    dcdc_day_split u_day (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_day_number (i_in_data.day_number),
        .o_parts      (parts)
    );

    dcdc_month u_month (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_parts        (parts),
        .o_year         (year),
        .o_month        (month),
        .o_day_of_month (dom)
    );

    dcdc_tod_split u_tod (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_time_seconds (i_in_data.time_seconds),
        .o_tod          (tod)
    );

    // A seconds value of a day or more rejects the whole result.
    assign o_out_valid             = r_vld[LATENCY-1];
    assign o_out_data.year         = tod.ok ? year  : '0;
    assign o_out_data.month        = tod.ok ? month : '0;
    assign o_out_data.day_of_month = tod.ok ? dom   : '0;
    assign o_out_data.hour         = tod.ok ? tod.hour   : '0;
    assign o_out_data.minute       = tod.ok ? tod.minute : '0;
    assign o_out_data.second       = tod.ok ? tod.second : '0;
    assign o_out_data.valid_res    = tod.ok;

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_res |->
            o_out_data.month >= 4'd1 && o_out_data.month <= 4'd12
            && o_out_data.day_of_month >= 5'd1 && o_out_data.day_of_month <= 5'd31
            && o_out_data.hour <= 5'd23 && o_out_data.minute <= 6'd59
            && o_out_data.second <= 6'd59)
        else $error("calendar fields out of range");

    a_february_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_res && o_out_data.month == 4'd2 |->
            o_out_data.day_of_month <= 5'd29)
        else $error("February day beyond 29");

    a_year_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_res |-> o_out_data.year != 16'd0)
        else $error("accepted result with year zero");

endmodule

`default_nettype wire
